/* design/spr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the shortest-path edge relaxer.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int unsigned NODE_COUNT_DEFAULT = 1024;

   localparam int unsigned NODE_W   = 10;
   localparam int unsigned DIST_W   = 40;
   localparam int unsigned WEIGHT_W = 32;
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned CSR_IDX_W = 1;

   // Infinity resets to 99999999 whole units in Q32.8.
   localparam logic [DIST_W-1:0] INF_WHOLE_UNITS = DIST_W'(99999999);
   localparam logic [DIST_W-1:0] INF_RESET_VALUE = INF_WHOLE_UNITS << 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT   = 2'd0,
      FUNC_RELAX  = 2'd1,
      FUNC_COMMIT = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_NODE = 1'b0,
      CSR_INFINITY    = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic fire;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } ctrl_sts_type;

endpackage

/* design/spr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer that takes one beat, lets the datapath read and update the
// distance tables, and hands the result to the output register.
// ----------------------------------------------------------------------------
module spr_ctrl
   import spr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!sts.out_blocked) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.fire    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.fire = !sts.out_blocked;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* design/spr_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_dp
// Distance tables, configuration registers, relaxation arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module spr_dp
   import spr_pkg::*;
#(
   parameter int unsigned NODE_COUNT = NODE_COUNT_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [NODE_W-1:0]     req_src_node,
   input  logic [NODE_W-1:0]     req_dst_node,
   input  logic [WEIGHT_W-1:0]   req_edge_weight,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIST_W-1:0]     csr_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_woken,
   output logic [NODE_W-1:0]     rsp_woken_node,
   output logic [DIST_W-1:0]     rsp_node_distance
);

   localparam int unsigned AddrW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned ExtW  = 32;

   logic [DIST_W-1:0] committed_mem [NODE_COUNT];
   logic [DIST_W-1:0] tentative_mem [NODE_COUNT];

   logic [NODE_W-1:0] source_node_ff;
   logic [DIST_W-1:0] infinity_ff;

   logic [ExtW-1:0]  src_ext;
   logic [ExtW-1:0]  dst_ext;
   logic [AddrW-1:0] src_addr;
   logic [AddrW-1:0] dst_addr;
   logic             src_ok;
   logic             dst_ok;

   func_type          func_ff;
   logic              src_ok_ff;
   logic              dst_ok_ff;
   logic [AddrW-1:0]  dst_addr_ff;
   logic [NODE_W-1:0] dst_node_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [DIST_W-1:0] comm_rd_ff;
   logic [DIST_W-1:0] tent_rd_ff;

   logic [DIST_W:0]   sum_wide;
   logic [DIST_W-1:0] sum_sat;
   logic              lower;
   logic [DIST_W-1:0] init_val;
   logic              wr_comm;
   logic              wr_tent;
   logic [DIST_W-1:0] wr_comm_data;
   logic [DIST_W-1:0] wr_tent_data;
   logic              woken_in;
   logic [DIST_W-1:0] dist_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_woken_ff;
   logic [NODE_W-1:0] rsp_node_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   assign src_ext  = {(ExtW - NODE_W)'(0), req_src_node};
   assign dst_ext  = {(ExtW - NODE_W)'(0), req_dst_node};
   assign src_addr = src_ext[AddrW-1:0];
   assign dst_addr = dst_ext[AddrW-1:0];
   assign src_ok   = src_ext < ExtW'(NODE_COUNT);
   assign dst_ok   = dst_ext < ExtW'(NODE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         source_node_ff <= '0;
         infinity_ff    <= INF_RESET_VALUE;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_NODE: source_node_ff <= csr_write_data[NODE_W-1:0];
            CSR_INFINITY:    infinity_ff    <= csr_write_data;
            default:         source_node_ff <= source_node_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= func_type'(req_func);
         src_ok_ff   <= src_ok;
         dst_ok_ff   <= dst_ok;
         dst_addr_ff <= dst_addr;
         dst_node_ff <= req_dst_node;
         weight_ff   <= req_edge_weight;
         comm_rd_ff  <= committed_mem[src_addr];
         tent_rd_ff  <= tentative_mem[dst_addr];
      end
   end

   assign sum_wide = {1'b0, comm_rd_ff} + {(DIST_W + 1 - WEIGHT_W)'(0), weight_ff};
   assign sum_sat  = sum_wide[DIST_W] ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];
   assign lower    = sum_sat < tent_rd_ff;
   assign init_val = (dst_node_ff == source_node_ff) ? '0 : infinity_ff;

   always_comb begin
      wr_comm      = 1'b0;
      wr_tent      = 1'b0;
      wr_comm_data = tent_rd_ff;
      wr_tent_data = sum_sat;
      woken_in     = 1'b0;
      dist_in      = tent_rd_ff;
      case (func_ff)
         FUNC_INIT: begin
            wr_comm      = 1'b1;
            wr_tent      = 1'b1;
            wr_comm_data = init_val;
            wr_tent_data = init_val;
            dist_in      = init_val;
         end
         FUNC_RELAX: begin
            if (!src_ok_ff) begin
               dist_in = '0;
            end else if (lower) begin
               wr_tent  = 1'b1;
               woken_in = 1'b1;
               dist_in  = sum_sat;
            end
         end
         FUNC_COMMIT: begin
            wr_comm = 1'b1;
         end
         default: begin
            dist_in = tent_rd_ff;
         end
      endcase
      if (!dst_ok_ff) begin
         wr_comm  = 1'b0;
         wr_tent  = 1'b0;
         woken_in = 1'b0;
         dist_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire && wr_comm) begin
         committed_mem[dst_addr_ff] <= wr_comm_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire && wr_tent) begin
         tentative_mem[dst_addr_ff] <= wr_tent_data;
      end
   end

   assign sts.out_blocked = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in    = cmd.fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         rsp_woken_ff <= woken_in;
         rsp_node_ff  <= dst_node_ff;
         rsp_dist_ff  <= dist_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_woken         = rsp_woken_ff;
   assign rsp_woken_node    = rsp_node_ff;
   assign rsp_node_distance = rsp_dist_ff;

endmodule

/* design/shortest_path_edge_relaxer.sv */
`timescale 1ns / 1ps
// A beat's table reads are registered when it is accepted; the compare and table
// write follow in the execute state, which also loads the result register. A new
// beat is accepted only after the previous one has left the execute state.
// A stalled result holds the block in its execute state until it is taken.
// Reset clears the controller, the result valid and the configuration
// registers; the distance tables are not cleared and must be initialized.
// ----------------------------------------------------------------------------
// shortest_path_edge_relaxer
// Bellman-Ford edge relaxation over committed and tentative distance tables.
// ----------------------------------------------------------------------------
module shortest_path_edge_relaxer
   import spr_pkg::*;
#(
   parameter int unsigned NODE_COUNT = NODE_COUNT_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [NODE_W-1:0]     req_src_node,
   input  logic [NODE_W-1:0]     req_dst_node,
   input  logic [WEIGHT_W-1:0]   req_edge_weight,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_woken,
   output logic [NODE_W-1:0]     rsp_woken_node,
   output logic [DIST_W-1:0]     rsp_node_distance,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIST_W-1:0]     csr_write_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spr_dp #(
      .NODE_COUNT (NODE_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_src_node      (req_src_node),
      .req_dst_node      (req_dst_node),
      .req_edge_weight   (req_edge_weight),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_woken         (rsp_woken),
      .rsp_woken_node    (rsp_woken_node),
      .rsp_node_distance (rsp_node_distance)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("beat accepted while another beat is in flight");

   a_fire_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   a_result_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.fire))
      else $error("result appeared without an executed beat");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the shortest-path edge relaxer. A directed
// sequence covers the source node, equal distances, commits of nodes that
// were not woken and sum saturation; random phases then load a new source
// and infinity, initialize a small working set of nodes and stream relax,
// commit and init beats over it. A predictor class keeps its own copy of
// both distance tables and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
   import spr_pkg::*;

   localparam int unsigned NODE_COUNT     = NODE_COUNT_DEFAULT;
   localparam int          ITEM_TARGET    = 1550;
   localparam int          QUIET_ITEMS    = 200;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct {
      logic              woken;
      logic [NODE_W-1:0] node;
      logic [DIST_W-1:0] distance;
   } node_report_type;

   class distance_tracker_type;
      logic [DIST_W-1:0] committed_dist [NODE_COUNT_DEFAULT];
      logic [DIST_W-1:0] tentative_dist [NODE_COUNT_DEFAULT];
      logic [NODE_W-1:0] source_node;
      logic [DIST_W-1:0] infinity_dist;
      node_report_type   due_reports [$];
      int                errors;

      function new();
         source_node   = '0;
         infinity_dist = INF_RESET_VALUE;
         errors        = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [DIST_W-1:0] value);
         case (idx)
            CSR_SOURCE_NODE: source_node = value[NODE_W-1:0];
            CSR_INFINITY:    infinity_dist = value;
            default:         ;
         endcase
      endfunction

      function int outstanding();
         return due_reports.size();
      endfunction

      function void note_item(func_type func, logic [NODE_W-1:0] src,
                              logic [NODE_W-1:0] dst, logic [WEIGHT_W-1:0] weight);
         node_report_type   report;
         logic [DIST_W:0]   sum;
         logic [DIST_W-1:0] capped;
         report.woken = 1'b0;
         report.node  = dst;
         case (func)
            FUNC_INIT: begin
               committed_dist[dst] = (dst == source_node) ? '0 : infinity_dist;
               tentative_dist[dst] = committed_dist[dst];
            end
            FUNC_RELAX: begin
               sum    = {1'b0, committed_dist[src]} + weight;
               capped = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
               if (capped < tentative_dist[dst]) begin
                  tentative_dist[dst] = capped;
                  report.woken = 1'b1;
               end
            end
            FUNC_COMMIT: begin
               committed_dist[dst] = tentative_dist[dst];
            end
            default: ;
         endcase
         report.distance = tentative_dist[dst];
         due_reports = {due_reports, report};
      endfunction

      function void check_report(logic woken, logic [NODE_W-1:0] node,
                                 logic [DIST_W-1:0] distance);
         node_report_type want;
         if (due_reports.size() == 0) begin
            $error("result beat with no expected result: node %0d", node);
            errors++;
            return;
         end
         want = due_reports.pop_front();
         if (woken !== want.woken) begin
            $error("woken: expected %0d, got %0d", want.woken, woken);
            errors++;
         end
         if (node !== want.node) begin
            $error("woken_node: expected %0d, got %0d", want.node, node);
            errors++;
         end
         if (distance !== want.distance) begin
            $error("node_distance: expected %0d, got %0d", want.distance, distance);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = FUNC_INIT;
   logic [NODE_W-1:0]    req_src_node = '0;
   logic [NODE_W-1:0]    req_dst_node = '0;
   logic [WEIGHT_W-1:0]  req_edge_weight = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_woken;
   logic [NODE_W-1:0]    rsp_woken_node;
   logic [DIST_W-1:0]    rsp_node_distance;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SOURCE_NODE;
   logic [DIST_W-1:0]    csr_write_data = '0;

   distance_tracker_type dist_tracker = new();
   int              items_sent = 0;
   int              gap_pct = 25;
   bit              idle_off = 1'b0;
   int              idle_cycles = 0;

   shortest_path_edge_relaxer #(
      .NODE_COUNT(NODE_COUNT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_src_node(req_src_node),
      .req_dst_node(req_dst_node),
      .req_edge_weight(req_edge_weight),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_woken(rsp_woken),
      .rsp_woken_node(rsp_woken_node),
      .rsp_node_distance(rsp_node_distance),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            dist_tracker.note_item(func_type'(req_func), req_src_node, req_dst_node,
                                   req_edge_weight);
         end
         if (rsp_valid && !rsp_stall) begin
            dist_tracker.check_report(rsp_woken, rsp_woken_node, rsp_node_distance);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         if (!idle_off) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [NODE_W-1:0] rand_node();
      return NODE_W'($urandom_range(0, NODE_COUNT - 1));
   endfunction

   task automatic send_item(func_type func, logic [NODE_W-1:0] src,
                            logic [NODE_W-1:0] dst, logic [WEIGHT_W-1:0] weight);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_src_node    <= src;
      req_dst_node    <= dst;
      req_edge_weight <= weight;
      items_sent++;
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
         idle_off = 1'b1;
      end
      do @(posedge clock); while (req_stall);
      if (!idle_off && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (dist_tracker.outstanding() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [DIST_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      dist_tracker.set_register(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [NODE_W-1:0]   work_nodes [0:23];
      logic [NODE_W-1:0]   src_val;
      logic [DIST_W-1:0]   inf_val;
      logic [WEIGHT_W-1:0] weight;
      int                  n_nodes;
      int                  n_ops;
      int                  a;
      int                  b;
      int                  pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset configuration: source 0.
      send_item(FUNC_INIT, rand_node(), 10'd0, $urandom());
      send_item(FUNC_INIT, rand_node(), 10'd1023, $urandom());
      send_item(FUNC_INIT, rand_node(), 10'd5, $urandom());
      send_item(FUNC_RELAX, 10'd0, 10'd1023, 32'd0);
      send_item(FUNC_RELAX, 10'd0, 10'd5, 32'hFFFF_FFFF);
      send_item(FUNC_RELAX, 10'd0, 10'd5, 32'hFFFF_FFFF);
      send_item(FUNC_RELAX, 10'd5, 10'd1023, 32'd1);
      send_item(FUNC_COMMIT, rand_node(), 10'd5, $urandom());
      send_item(FUNC_COMMIT, rand_node(), 10'd1023, $urandom());
      send_item(FUNC_RELAX, 10'd1023, 10'd5, 32'd100);
      send_item(FUNC_INIT, rand_node(), 10'd7, $urandom());
      send_item(FUNC_COMMIT, rand_node(), 10'd7, $urandom());
      send_item(FUNC_RELAX, 10'd7, 10'd7, 32'd0);

      // A full-scale infinity makes any sum from an unreached node saturate.
      wait_for_drain();
      write_csr(CSR_SOURCE_NODE, DIST_W'(1023));
      write_csr(CSR_INFINITY, DIST_MAX);
      send_item(FUNC_INIT, rand_node(), 10'd9, $urandom());
      send_item(FUNC_RELAX, 10'd9, 10'd9, 32'hFFFF_FFFF);
      send_item(FUNC_INIT, rand_node(), 10'd1023, $urandom());
      send_item(FUNC_RELAX, 10'd9, 10'd1023, 32'd5);
      send_item(FUNC_RELAX, 10'd1023, 10'd9, 32'd3);

      // Just below full scale, a wrapped sum would wake the node.
      wait_for_drain();
      write_csr(CSR_INFINITY, DIST_MAX - 40'd10);
      send_item(FUNC_INIT, rand_node(), 10'd11, $urandom());
      send_item(FUNC_RELAX, 10'd11, 10'd11, 32'd1000);
      send_item(FUNC_INIT, rand_node(), 10'd12, $urandom());
      send_item(FUNC_RELAX, 10'd11, 10'd12, 32'd5);

      wait_for_drain();
      write_csr(CSR_SOURCE_NODE, DIST_W'(0));
      write_csr(CSR_INFINITY, '0);
      send_item(FUNC_INIT, rand_node(), 10'd13, $urandom());
      send_item(FUNC_RELAX, 10'd13, 10'd13, 32'd0);
      send_item(FUNC_INIT, rand_node(), 10'd0, $urandom());

      while (items_sent < ITEM_TARGET) begin
         wait_for_drain();
         case ($urandom_range(0, 5))
            0:       src_val = '0;
            1:       src_val = NODE_W'(NODE_COUNT - 1);
            default: src_val = rand_node();
         endcase
         case ($urandom_range(0, 5))
            0:       inf_val = '0;
            1:       inf_val = DIST_MAX;
            2:       inf_val = INF_RESET_VALUE;
            3:       inf_val = DIST_MAX - DIST_W'($urandom_range(0, 1 << 16));
            4:       inf_val = DIST_W'($urandom_range(0, 1 << 20));
            default: inf_val = {8'($urandom_range(0, 255)), 32'($urandom())};
         endcase
         write_csr(CSR_SOURCE_NODE, DIST_W'(src_val));
         write_csr(CSR_INFINITY, inf_val);
         gap_pct = 10 * $urandom_range(0, 4);

         n_nodes = $urandom_range(3, 20);
         for (int i = 0; i < n_nodes; i++) begin
            work_nodes[i] = rand_node();
         end
         if ($urandom_range(0, 3) != 0) begin
            work_nodes[$urandom_range(0, n_nodes - 1)] = src_val;
         end
         for (int i = 0; i < n_nodes; i++) begin
            send_item(FUNC_INIT, rand_node(), work_nodes[i], $urandom());
         end

         n_ops = $urandom_range(50, 150);
         for (int j = 0; j < n_ops && items_sent < ITEM_TARGET; j++) begin
            pick = $urandom_range(0, 99);
            a = $urandom_range(0, n_nodes - 1);
            b = $urandom_range(0, n_nodes - 1);
            if (pick < 60) begin
               case ($urandom_range(0, 3))
                  0, 1:    weight = WEIGHT_W'($urandom_range(0, 2048));
                  2:       weight = WEIGHT_W'($urandom_range(0, 1 << 24));
                  default: weight = $urandom();
               endcase
               send_item(FUNC_RELAX, work_nodes[a], work_nodes[b], weight);
            end else if (pick < 85) begin
               send_item(FUNC_COMMIT, rand_node(), work_nodes[a], $urandom());
            end else if (pick < 93) begin
               send_item(FUNC_INIT, rand_node(), work_nodes[a], $urandom());
            end else begin
               work_nodes[a] = rand_node();
               send_item(FUNC_INIT, rand_node(), work_nodes[a], $urandom());
            end
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (dist_tracker.errors == 0 && dist_tracker.outstanding() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
